FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ntd_pkg.sv
// ---------------------------------------------------------------------------
// Nucleotide trie dictionary package
// Sizes, node entry layout and node store request shared by the block.
// ---------------------------------------------------------------------------
package ntd_pkg;

    localparam int MAX_LEN    = 12;
    localparam int NODE_COUNT = 65536;
    localparam int SYM_W      = 2;
    localparam int SYMS_W     = 24;
    localparam int LEN_W      = 4;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = NODE_W + 1;
    localparam int FANOUT     = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef logic [NODE_W-1:0] node_idx_t;

    typedef struct packed {
        logic                         mark;
        logic [FANOUT-1:0][NODE_W-1:0] links;
    } entry_t;

    typedef struct packed {
        logic      rd_en;
        logic      wr_en;
        node_idx_t addr;
        entry_t    wr_data;
    } store_req_t;

endpackage

FILE: rtl/ntd_node_store.sv
// ---------------------------------------------------------------------------
// Node store
// Single-port trie node memory; the root lives in reset-cleared registers.
// ---------------------------------------------------------------------------
module ntd_node_store (
    input  logic                clk,
    input  logic                rst_n,
    input  ntd_pkg::store_req_t req,
    output ntd_pkg::entry_t     q
);
    import ntd_pkg::*;

    entry_t mem [NODE_COUNT];
    entry_t mem_q_reg;
    entry_t root_reg;
    logic   rd_root_reg;
    logic   is_root;

    assign is_root = (req.addr == '0);

    always_ff @(posedge clk)
    begin
        if (req.wr_en && !is_root)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= '0;
            rd_root_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en && is_root)
            begin
                root_reg <= req.wr_data;
            end
            if (req.rd_en)
            begin
                rd_root_reg <= is_root;
            end
        end
    end

    assign q = rd_root_reg ? root_reg : mem_q_reg;

endmodule

FILE: rtl/nucleotide_trie_dictionary.sv
// ---------------------------------------------------------------------------
// Nucleotide trie dictionary
// Insert and find of ACGT strings of up to 12 symbols in a trie node store.
//
// Command channel: a word is taken at a clock edge with start high and busy
// low; busy stays high while the word is walked through the trie.
// Result channel: done is high for exactly one cycle with found and status;
// the receiver cannot stall, so results are never held back.
// Steps: for each symbol the current node is read (S_LOAD) and its link
// followed (S_CHECK); a missing link on insert writes the parent's new link
// in S_CHECK and zeroes the fresh node in S_CLEAR; the final node is read
// and checked, its mark written on insert, and the result registered. The
// node store has a single port, so these reads and writes follow in turn.
// A new word may be taken in the cycle that done is high.
// Reset empties the dictionary at once: the root is held in registers that
// reset clears and the free-node counter returns to one; there is no
// clearing pass. Once all 65536 nodes are in use, an insert that needs
// another node stops with status high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nucleotide_trie_dictionary (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cmd,
    input  logic [ntd_pkg::SYMS_W-1:0] symbols,
    input  logic [ntd_pkg::LEN_W-1:0]  length,
    input  logic                       bad_symbol,
    output logic                       done,
    output logic                       found,
    output logic                       status
);
    import ntd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              cmd_reg, cmd_next;
    logic              bad_reg, bad_next;
    logic [SYMS_W-1:0] syms_reg, syms_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    node_idx_t         node_reg, node_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic              status_reg, status_next;

    store_req_t        req;
    entry_t            q;
    entry_t            upd;
    node_idx_t         child;
    logic [SYM_W-1:0]  sym;
    logic              full;
    logic [LEN_W-1:0]  len_clamped;

    ntd_node_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .q     (q)
    );

    assign sym         = syms_reg[SYM_W-1:0];
    assign child       = q.links[sym];
    assign full        = (free_reg == CNT_W'(NODE_COUNT));
    assign len_clamped = (length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        bad_next    = bad_reg;
        syms_next   = syms_reg;
        rem_next    = rem_reg;
        node_next   = node_reg;
        free_next   = free_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        status_next = status_reg;
        req         = '0;
        upd         = q;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    bad_next   = bad_symbol;
                    syms_next  = symbols;
                    rem_next   = len_clamped;
                    node_next  = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                req.rd_en  = 1'b1;
                req.addr   = node_reg;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rem_reg == '0)
                begin
                    // end of string: mark on insert, report mark on find, unless the word is bad
                    found_next  = (cmd_reg == CMD_FIND) && q.mark && !bad_reg;
                    status_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    if ((cmd_reg == CMD_INSERT) && !bad_reg)
                    begin
                        upd.mark    = 1'b1;
                        req.wr_en   = 1'b1;
                        req.addr    = node_reg;
                        req.wr_data = upd;
                    end
                end
                else if (child != '0)
                begin
                    node_next  = child;
                    rem_next   = rem_reg - LEN_W'(1);
                    syms_next  = syms_reg >> SYM_W;
                    state_next = S_LOAD;
                end
                else if (cmd_reg == CMD_FIND)
                begin
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (full)
                begin
                    found_next  = 1'b0;
                    status_next = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // link the parent to a fresh node
                    upd.links[sym] = free_reg[NODE_W-1:0];
                    req.wr_en      = 1'b1;
                    req.addr       = node_reg;
                    req.wr_data    = upd;
                    node_next      = free_reg[NODE_W-1:0];
                    free_next      = free_reg + CNT_W'(1);
                    rem_next       = rem_reg - LEN_W'(1);
                    syms_next      = syms_reg >> SYM_W;
                    state_next     = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                req.wr_en   = 1'b1;
                req.addr    = node_reg;
                req.wr_data = '0;
                state_next  = S_LOAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            free_reg   <= CNT_W'(1);
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        bad_reg  <= bad_next;
        syms_reg <= syms_next;
        rem_reg  <= rem_next;
        node_reg <= node_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign found  = found_reg;
    assign status = status_reg;

    `ASSERT_IMPLIES(a_done_after_work, clk, rst_n, done, $past(state_reg) == S_CHECK)
    `ASSERT_ALWAYS(a_free_in_range, clk, rst_n, free_reg <= CNT_W'(NODE_COUNT) && free_reg != '0)
    `ASSERT_IMPLIES(a_status_on_insert, clk, rst_n, done && status, cmd_reg == CMD_INSERT)
    `ASSERT_IMPLIES(a_found_on_find, clk, rst_n, done && found, cmd_reg == CMD_FIND)
    `ASSERT_IMPLIES(a_busy_from_start, clk, rst_n, $rose(busy), $past(start))

endmodule

FILE: dv/tb_nucleotide_trie_dictionary.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Nucleotide trie dictionary testbench
// Drives insert and find words through the command handshake and mirrors the
// trie in a scoreboard class that predicts found and status for every word.
// Each result is checked in order against the oldest prediction. The run
// covers directed corner strings and a random mix that mostly revisits
// stored strings and their prefixes, with a pause to drain midway.
// ---------------------------------------------------------------------------
module tb_nucleotide_trie_dictionary;

    import ntd_pkg::*;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;
    localparam int   QUIET_LIMIT = 1000;
    localparam int   RANDOM_WORDS = 950;
    localparam int   POOL_DEPTH  = 64;

    typedef struct packed {
        logic found;
        logic status;
    } answer_t;

    typedef struct packed {
        logic [SYMS_W-1:0] syms;
        logic [LEN_W-1:0]  len;
    } dna_string_t;

    class trie_mirror;
        bit [NODE_W-1:0] kids [NODE_COUNT][FANOUT];
        bit              marked [NODE_COUNT];
        int unsigned     next_node;
        answer_t         awaited [$];
        int unsigned     mismatches;

        function new();
            next_node  = 1;
            mismatches = 0;
        endfunction

        function void take_word(logic op, logic [SYMS_W-1:0] syms,
                                logic [LEN_W-1:0] len, logic bad);
            int unsigned depth;
            int unsigned node;
            int unsigned nxt;
            int unsigned i;
            int unsigned j;
            bit          full;
            bit          walking;
            answer_t     ans;
            depth   = (len > MAX_LEN) ? MAX_LEN : len;
            node    = 0;
            full    = 1'b0;
            walking = !bad;
            ans     = '{found: 1'b0, status: STATUS_OK};
            if (op == CMD_INSERT) begin
                for (i = 0; !full && i < depth; i++) begin
                    nxt = kids[node][syms[2*i +: 2]];
                    if (nxt == 0 && next_node >= NODE_COUNT) begin
                        full = 1'b1;
                    end
                    else begin
                        if (nxt == 0) begin
                            nxt = next_node;
                            next_node++;
                            for (j = 0; j < FANOUT; j++)
                                kids[nxt][j] = '0;
                            marked[nxt] = 1'b0;
                            kids[node][syms[2*i +: 2]] = NODE_W'(nxt);
                        end
                        node = nxt;
                    end
                end
                if (full)
                    ans.status = STATUS_FULL;
                else if (!bad)
                    marked[node] = 1'b1;
            end
            else begin
                for (i = 0; walking && i < depth; i++) begin
                    nxt = kids[node][syms[2*i +: 2]];
                    if (nxt == 0)
                        walking = 1'b0;
                    else
                        node = nxt;
                end
                ans.found = walking && marked[node];
            end
            awaited.push_back(ans);
        endfunction

        function void check_answer(logic found_q, logic status_q);
            answer_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual found=%0b status=%0b",
                         $time, found_q, status_q);
                mismatches++;
            end
            else begin
                want = awaited.pop_front();
                if (found_q !== want.found) begin
                    $display("%0t: found: expected %0b, actual %0b",
                             $time, want.found, found_q);
                    mismatches++;
                end
                if (status_q !== want.status) begin
                    $display("%0t: status: expected %0b, actual %0b",
                             $time, want.status, status_q);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              cmd        = CMD_INSERT;
    logic [SYMS_W-1:0] symbols    = '0;
    logic [LEN_W-1:0]  length     = '0;
    logic              bad_symbol = 1'b0;
    logic              busy;
    logic              done;
    logic              found;
    logic              status;

    trie_mirror  mirror;
    dna_string_t stored [$];
    bit          gaps_on = 1'b1;
    int          quiet_cycles = 0;

    nucleotide_trie_dictionary i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .symbols    (symbols),
        .length     (length),
        .bad_symbol (bad_symbol),
        .done       (done),
        .found      (found),
        .status     (status)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_answer(found, status);
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic [SYMS_W-1:0] syms,
                             input logic [LEN_W-1:0] len, input logic bad);
        while (gaps_on && $urandom_range(99) < 13) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        symbols    <= syms;
        length     <= len;
        bad_symbol <= bad;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.take_word(op, syms, len, bad);
    endtask

    task automatic wait_all_answered();
        start <= 1'b0;
        do
            @(posedge clk);
        while (mirror.awaited.size() != 0);
    endtask

    task automatic random_word();
        logic              op;
        logic [SYMS_W-1:0] syms;
        logic [SYMS_W-1:0] tail;
        logic [LEN_W-1:0]  len;
        logic              bad;
        dna_string_t       pick;
        int                keep;
        op = ($urandom_range(99) < 45) ? CMD_INSERT : CMD_FIND;
        if (stored.size() > 0 && $urandom_range(99) < 65) begin
            pick = stored[$urandom_range(stored.size() - 1)];
            syms = pick.syms;
            len  = pick.len;
            case ($urandom_range(5))
                0: len = 4'($urandom_range(len));
                1: len = (len > 13) ? 4'd15 : len + 4'($urandom_range(2));
                2: begin
                    keep = $urandom_range(MAX_LEN);
                    tail = {SYMS_W{1'b1}} << (2 * keep);
                    syms = (syms & ~tail) | (SYMS_W'($urandom) & tail);
                end
                default: ;
            endcase
        end
        else begin
            syms = SYMS_W'($urandom);
            len  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 13))
                                            : 4'($urandom_range(MAX_LEN));
        end
        bad = ($urandom_range(99) < 8);
        if (op == CMD_INSERT && !bad) begin
            stored.push_back('{syms: syms, len: len});
            if (stored.size() > POOL_DEPTH)
                void'(stored.pop_front());
        end
        send_word(op, syms, len, bad);
    endtask

    initial
    begin
        int k;
        mirror = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_FIND,   24'h000000, 4'd0,  1'b0);
        send_word(CMD_INSERT, 24'h000000, 4'd0,  1'b0);
        send_word(CMD_FIND,   24'hFFFFFF, 4'd0,  1'b0);
        send_word(CMD_INSERT, 24'hFFFFFF, 4'd12, 1'b0);
        send_word(CMD_FIND,   24'hFFFFFF, 4'd12, 1'b0);
        send_word(CMD_FIND,   24'hFFFFFF, 4'd11, 1'b0);
        send_word(CMD_INSERT, 24'h000000, 4'd15, 1'b0);
        send_word(CMD_FIND,   24'h000000, 4'd13, 1'b0);
        send_word(CMD_FIND,   24'h000000, 4'd12, 1'b0);
        send_word(CMD_INSERT, 24'hABCDEF, 4'd5,  1'b1);
        send_word(CMD_FIND,   24'hABCDEF, 4'd5,  1'b0);
        send_word(CMD_FIND,   24'hABCDEF, 4'd4,  1'b0);
        send_word(CMD_INSERT, 24'hABCDEF, 4'd5,  1'b0);
        send_word(CMD_FIND,   24'hABCDEF, 4'd5,  1'b0);
        send_word(CMD_FIND,   24'hABCDEF, 4'd5,  1'b1);
        send_word(CMD_INSERT, 24'h123456, 4'd0,  1'b1);
        send_word(CMD_FIND,   24'h123456, 4'd0,  1'b1);
        send_word(CMD_INSERT, 24'h5A5A5A, 4'd14, 1'b0);
        send_word(CMD_FIND,   24'h5A5A5A, 4'd12, 1'b0);
        send_word(CMD_INSERT, 24'h5A5A5A, 4'd12, 1'b0);
        send_word(CMD_FIND,   24'h555555, 4'd14, 1'b0);
        send_word(CMD_INSERT, 24'hFFFFFF, 4'd6,  1'b0);
        send_word(CMD_FIND,   24'hFFFFFF, 4'd6,  1'b0);
        wait_all_answered();

        for (k = 0; k < RANDOM_WORDS; k++) begin
            gaps_on = (k < 400 || k >= 600);
            if (k == RANDOM_WORDS / 2)
                wait_all_answered();
            random_word();
        end

        wait_all_answered();
        repeat (64) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
